// ===== src/bfrf_pkg.sv =====
// Shared constants, codes and helpers for the bit-field register file.
// Used by bitfield_register_file_core; depends on nothing else.

package bfrf_pkg;

   localparam int VIRTUAL_COUNT   = 32;
   localparam int TEMPORARY_COUNT = 32;
   localparam int MACHINE_COUNT   = 32;
   localparam int TOTAL_COUNT     = VIRTUAL_COUNT + TEMPORARY_COUNT + MACHINE_COUNT;
   localparam int SLOT_W          = $clog2(TOTAL_COUNT);

   localparam int REG_WIDTH  = 64;                    // usable bits per register
   localparam int DATA_W     = 64;                    // storage and field width
   localparam int INDEX_W    = 5;
   localparam int LEN_W      = 7;
   localparam int OFF_W      = 6;
   localparam int EXT_W      = 7;
   localparam int END_W      = 8;                     // offset plus length
   localparam int WORD_W     = DATA_W + EXT_W;        // stored bits and extent

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 72;

   typedef enum logic [0:0] {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      BANK_VIRTUAL   = 2'd0,
      BANK_TEMPORARY = 2'd1,
      BANK_MACHINE   = 2'd2
   } bank_type;

   // Ones in the low len bits; len of 64 or more gives all ones.
   function automatic logic [DATA_W-1:0] field_mask(input logic [LEN_W-1:0] len);
      logic [DATA_W-1:0] ones;
      ones = {DATA_W{1'b1}};
      return ~(ones << len);
   endfunction

endpackage

// ===== src/bitfield_register_file_core.sv =====
// Bit-field register file: three banks of registers with field read and merge.
// Depends on bfrf_pkg for sizes, codes and the field mask helper.
//
//   channel  dir  tdata (low bit up)                                   tuser
//   req      in   bank, reg_index, field_length, field_offset,         op
//                 write_value, zero pad
//   rsp      out  read_value, written_extent, zero pad                  range_error
//
// One beat accepted per cycle, sustained while rsp_tready stays high. A request
// beat loads the request stage, and its result is then loaded into the result
// register, from which it is offered. The register store is one memory with a
// registered read port; a write forward path covers a read of the register
// written last. Reset clears one valid bit per register, so no clearing pass is
// run. A stalled result holds the request stage, and req_tready drops only
// while both stages hold a beat and rsp_tready is low.

module bitfield_register_file_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // bank[1:0], reg_index[6:2], field_length[13:7], field_offset[19:14],
   // write_value[83:20], zero[87:84]
   input  logic [bfrf_pkg::REQ_DATA_W-1:0]   req_tdata,
   // op
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // read_value[63:0], written_extent[70:64], zero[71]
   output logic [bfrf_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // range_error
   output logic                              rsp_tuser
);

   localparam int DW = bfrf_pkg::DATA_W;
   localparam int SW = bfrf_pkg::SLOT_W;
   localparam int EW = bfrf_pkg::EXT_W;
   localparam int NW = bfrf_pkg::END_W;

   // ---------------- input decode ----------------
   logic [1:0]                    in_bank;
   logic [bfrf_pkg::INDEX_W-1:0]  in_index;
   logic [bfrf_pkg::LEN_W-1:0]    in_len;
   logic [bfrf_pkg::OFF_W-1:0]    in_off;
   logic [DW-1:0]                 in_wdata;
   logic                          in_hit;
   logic [SW-1:0]                 in_slot;
   logic                          accept;
   logic                          advance;

   assign in_bank  = req_tdata[1:0];
   assign in_index = req_tdata[6:2];
   assign in_len   = req_tdata[13:7];
   assign in_off   = req_tdata[19:14];
   assign in_wdata = req_tdata[83:20];

   always_comb begin
      in_hit  = 1'b0;
      in_slot = '0;
      unique case (bfrf_pkg::bank_type'(in_bank))
         bfrf_pkg::BANK_VIRTUAL: begin
            in_hit  = 10'(in_index) < 10'(bfrf_pkg::VIRTUAL_COUNT);
            in_slot = SW'(in_index);
         end
         bfrf_pkg::BANK_TEMPORARY: begin
            in_hit  = 10'(in_index) < 10'(bfrf_pkg::TEMPORARY_COUNT);
            in_slot = SW'(bfrf_pkg::VIRTUAL_COUNT) + SW'(in_index);
         end
         bfrf_pkg::BANK_MACHINE: begin
            in_hit  = 10'(in_index) < 10'(bfrf_pkg::MACHINE_COUNT);
            in_slot = SW'(bfrf_pkg::VIRTUAL_COUNT + bfrf_pkg::TEMPORARY_COUNT)
                      + SW'(in_index);
         end
         default: begin
            in_hit  = 1'b0;
            in_slot = '0;
         end
      endcase
      // park unused addresses on slot zero so the store is never indexed out of range
      if (!in_hit) begin
         in_slot = '0;
      end
   end

   // ---------------- request stage ----------------
   logic                          s1_valid_ff, s1_valid_in;
   bfrf_pkg::op_type              s1_op_ff;
   logic                          s1_hit_ff;
   logic [SW-1:0]                 s1_slot_ff;
   logic [bfrf_pkg::LEN_W-1:0]    s1_len_ff;
   logic [bfrf_pkg::OFF_W-1:0]    s1_off_ff;
   logic [DW-1:0]                 s1_wdata_ff;

   assign advance    = s1_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= bfrf_pkg::op_type'(req_tuser);
         s1_hit_ff   <= in_hit;
         s1_slot_ff  <= in_slot;
         s1_len_ff   <= in_len;
         s1_off_ff   <= in_off;
         s1_wdata_ff <= in_wdata;
      end
   end

   // ---------------- register store ----------------
   logic [bfrf_pkg::WORD_W-1:0]   store [bfrf_pkg::TOTAL_COUNT];
   logic [bfrf_pkg::WORD_W-1:0]   mem_rd_ff;
   logic [bfrf_pkg::TOTAL_COUNT-1:0] entry_valid_ff;
   logic                          wr_valid_ff;
   logic [SW-1:0]                 wr_slot_ff;
   logic [bfrf_pkg::WORD_W-1:0]   wr_word_ff;
   logic                          wr_en;
   logic [bfrf_pkg::WORD_W-1:0]   new_word;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[s1_slot_ff] <= new_word;
      end
      if (accept) begin
         mem_rd_ff <= store[in_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         wr_valid_ff    <= 1'b0;
      end else if (wr_en) begin
         entry_valid_ff[s1_slot_ff] <= 1'b1;
         wr_valid_ff                <= 1'b1;
      end
   end

   // hold the latest write; it stands in for a read that raced it
   always_ff @(posedge clock) begin
      if (wr_en) begin
         wr_slot_ff <= s1_slot_ff;
         wr_word_ff <= new_word;
      end
   end

   // ---------------- field logic ----------------
   logic [bfrf_pkg::WORD_W-1:0]   cur_word;
   logic [DW-1:0]                 cur_data;
   logic [EW-1:0]                 cur_ext;
   logic [DW-1:0]                 mask;
   logic [NW-1:0]                 field_end;
   logic                          zero_len;
   logic                          over;
   logic                          ok_access;
   logic                          ok_write;
   logic [DW-1:0]                 new_data;
   logic [EW-1:0]                 new_ext;
   logic [DW-1:0]                 rd_value;
   logic [EW-1:0]                 rd_ext;
   logic                          rd_err;

   always_comb begin
      if (wr_valid_ff && (wr_slot_ff == s1_slot_ff)) begin
         cur_word = wr_word_ff;
      end else if (entry_valid_ff[s1_slot_ff]) begin
         cur_word = mem_rd_ff;
      end else begin
         cur_word = '0;
      end
   end

   assign cur_data  = cur_word[DW-1:0];
   assign cur_ext   = cur_word[bfrf_pkg::WORD_W-1:DW];
   assign mask      = bfrf_pkg::field_mask(s1_len_ff);
   assign field_end = NW'(s1_off_ff) + NW'(s1_len_ff);
   assign zero_len  = (s1_len_ff == '0);
   assign over      = field_end > NW'(bfrf_pkg::REG_WIDTH);
   assign ok_access = s1_hit_ff && !zero_len && !over;
   assign ok_write  = ok_access && (s1_op_ff == bfrf_pkg::OP_WRITE);
   assign wr_en     = advance && ok_write;

   assign new_data = (cur_data & ~(mask << s1_off_ff))
                   | ((s1_wdata_ff & mask) << s1_off_ff);
   assign new_ext  = (field_end > NW'(cur_ext)) ? EW'(field_end) : cur_ext;
   assign new_word = {new_ext, new_data};

   always_comb begin
      rd_value = '0;
      if (ok_access && (s1_op_ff == bfrf_pkg::OP_READ)) begin
         rd_value = (cur_data >> s1_off_ff) & mask;
      end
      if (!s1_hit_ff) begin
         rd_ext = '0;
      end else if (ok_write) begin
         rd_ext = new_ext;
      end else begin
         rd_ext = cur_ext;
      end
      rd_err = !s1_hit_ff || (!zero_len && over);
   end

   // ---------------- result register ----------------
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]                 rsp_value_ff;
   logic [EW-1:0]                 rsp_ext_ff;
   logic                          rsp_err_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_value_ff <= rd_value;
         rsp_ext_ff   <= rd_ext;
         rsp_err_ff   <= rd_err;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(bfrf_pkg::RSP_DATA_W - DW - EW){1'b0}}, rsp_ext_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_err_ff;

   // ---------------- checks ----------------
   a_err_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_value_ff == '0)
      else $error("refused access returned nonzero field");

   a_extent_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_ext_ff <= EW'(bfrf_pkg::REG_WIDTH))
      else $error("extent beyond register width");

   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && rsp_tvalid && !rsp_tready)
      else $error("request side blocked without a stall");

   a_write_forwarded: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> wr_valid_ff && entry_valid_ff[wr_slot_ff] && (wr_slot_ff == $past(s1_slot_ff)))
      else $error("write not captured for forwarding");

   a_bad_slot_no_write: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_hit_ff |-> !wr_en)
      else $error("write to an unmapped register");

endmodule
